// ----- rtl/core/stack_machine_executor_macros.svh -----
// assertion macros for the stack machine executor checker
// expects clk and rst to be visible where the macros are used
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// same-cycle implication, off during reset
`define SMX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SMX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define SMX_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/smx_pkg.sv -----
// shared widths, opcodes, status codes and structs of the stack machine executor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

  localparam int OP_W     = 4;
  localparam int WORD_W   = 32;
  localparam int TGT_W    = 10;
  localparam int NEXT_W   = 10;
  localparam int STATUS_W = 3;

  localparam int DATA_DEPTH_DEF    = 1024;
  localparam int STACK_DEPTH_DEF   = 1024;
  localparam int PROGRAM_DEPTH_DEF = 1024;

  // opcodes
  localparam logic [OP_W-1:0] OP_LD  = 4'd0;
  localparam logic [OP_W-1:0] OP_ST  = 4'd1;
  localparam logic [OP_W-1:0] OP_LDC = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB = 4'd4;
  localparam logic [OP_W-1:0] OP_CMP = 4'd5;
  localparam logic [OP_W-1:0] OP_JMP = 4'd6;
  localparam logic [OP_W-1:0] OP_BR  = 4'd7;
  localparam logic [OP_W-1:0] OP_RET = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RET   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE  = 3'd5;

  // decoded request handed from issue to execute
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [STATUS_W-1:0] status;
    logic                stack_wr;
    logic                data_wr;
    logic                fwd_stack;
    logic                fwd_data;
    logic [WORD_W-1:0]   operand;
    logic [TGT_W-1:0]    target;
    logic [TGT_W-1:0]    tq;
  } issue_t;

  // one result
  typedef struct packed {
    logic [NEXT_W-1:0]   next_pc;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   value;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/stack_machine_executor.sv -----
// stack machine executor top: issue, execute, data and stack rams, output queue
// path: an accepted request is registered toward execute, its result into the output queue
// throughput: one request per cycle while in_ready is high, one ram read-modify-write each
// reset: a sweep over every data ram address zeroes the data ram, in_ready stays low meanwhile
// depends on smx_pkg, smx_ram, smx_issue, smx_exec
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor #(
  parameter int DATA_DEPTH    = smx_pkg::DATA_DEPTH_DEF,
  parameter int STACK_DEPTH   = smx_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_DEPTH = smx_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smx_pkg::OP_W-1:0]          operation,
  input  logic signed [smx_pkg::WORD_W-1:0] operand,
  input  logic [smx_pkg::TGT_W-1:0]         jump_target,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smx_pkg::NEXT_W-1:0]        next_pc,
  output logic [smx_pkg::STATUS_W-1:0]      status,
  output logic signed [smx_pkg::WORD_W-1:0] result_value
);

  import smx_pkg::*;

  localparam int DA_W = $clog2(DATA_DEPTH);
  localparam int SA_W = $clog2(STACK_DEPTH);

  logic              accept;
  logic              clearing;
  logic [DA_W-1:0]   clr_addr;
  logic [DA_W-1:0]   data_raddr;
  logic [SA_W-1:0]   stack_raddr;
  logic              iss_valid;
  issue_t            iss;
  logic [DA_W-1:0]   iss_daddr;
  logic [SA_W-1:0]   iss_saddr;
  logic [WORD_W-1:0] stack_rdata;
  logic [WORD_W-1:0] data_rdata;
  logic              stack_we;
  logic [SA_W-1:0]   stack_waddr;
  logic [WORD_W-1:0] stack_wdata;
  logic              data_we;
  logic [DA_W-1:0]   data_waddr;
  logic [WORD_W-1:0] data_wdata;
  logic              dmem_we;
  logic [DA_W-1:0]   dmem_waddr;
  logic [WORD_W-1:0] dmem_wdata;
  logic              res_valid;
  result_t           res;
  result_t           q0;
  result_t           q1;
  logic [1:0]        q_cnt;
  logic [1:0]        load;
  logic              pop;

  // handshakes: room is counted over the execute stage and the queue
  assign pop       = out_valid && out_ready;
  assign load      = q_cnt + {1'b0, iss_valid} - {1'b0, pop};
  assign in_ready  = !clearing && (load < 2'd2);
  assign accept    = in_valid && in_ready;
  assign out_valid = (q_cnt != 2'd0);

  assign next_pc      = q0.next_pc;
  assign status       = q0.status;
  assign result_value = q0.value;

  smx_issue #(
    .DATA_DEPTH   (DATA_DEPTH),
    .STACK_DEPTH  (STACK_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (operation),
    .operand    (operand),
    .jump_target(jump_target),
    .clearing   (clearing),
    .clr_addr   (clr_addr),
    .data_raddr (data_raddr),
    .stack_raddr(stack_raddr),
    .iss_valid  (iss_valid),
    .iss        (iss),
    .iss_daddr  (iss_daddr),
    .iss_saddr  (iss_saddr)
  );

  smx_exec #(
    .DATA_DEPTH   (DATA_DEPTH),
    .STACK_DEPTH  (STACK_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .iss_valid  (iss_valid),
    .iss        (iss),
    .iss_daddr  (iss_daddr),
    .iss_saddr  (iss_saddr),
    .stack_rdata(stack_rdata),
    .data_rdata (data_rdata),
    .stack_we   (stack_we),
    .stack_waddr(stack_waddr),
    .stack_wdata(stack_wdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  // data ram write port shared by the clear sweep and st
  assign dmem_we    = clearing || data_we;
  assign dmem_waddr = clearing ? clr_addr : data_waddr;
  assign dmem_wdata = clearing ? '0 : data_wdata;

  smx_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DATA_DEPTH)
  ) u_data_ram (
    .clk  (clk),
    .we   (dmem_we),
    .waddr(dmem_waddr),
    .wdata(dmem_wdata),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  smx_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(stack_wdata),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt + {1'b0, res_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && res_valid) begin
      if (q_cnt == 2'd2) begin
        q0 <= q1;
        q1 <= res;
      end else begin
        q0 <= res;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (res_valid) begin
      if (q_cnt == 2'd0) q0 <= res;
      else q1 <= res;
    end else begin
      // queue holds
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smx_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/smx_issue.sv -----
// issue stage: decode, stack count, halt flag, read addresses, forwarding, clear sweep
// depends on smx_pkg
`timescale 1ns / 1ps
`default_nettype none

module smx_issue #(
  parameter int DATA_DEPTH    = 1024,
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [smx_pkg::OP_W-1:0]           operation,
  input  logic signed [smx_pkg::WORD_W-1:0]  operand,
  input  logic [smx_pkg::TGT_W-1:0]          jump_target,
  output logic                               clearing,
  output logic [$clog2(DATA_DEPTH)-1:0]      clr_addr,
  output logic [$clog2(DATA_DEPTH)-1:0]      data_raddr,
  output logic [$clog2(STACK_DEPTH)-1:0]     stack_raddr,
  output logic                               iss_valid,
  output smx_pkg::issue_t                    iss,
  output logic [$clog2(DATA_DEPTH)-1:0]      iss_daddr,
  output logic [$clog2(STACK_DEPTH)-1:0]     iss_saddr
);

  import smx_pkg::*;

  localparam int DA_W     = $clog2(DATA_DEPTH);
  localparam int SA_W     = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int TQ_SHIFT = TGT_W + $clog2(PROGRAM_DEPTH);
  localparam int TQ_RECIP = ((1 << TQ_SHIFT) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;
  localparam int MUL_W    = 2 * TGT_W + 2;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                halted;
  logic                addr_ok;
  logic                full;
  logic                empty;
  logic                short_stack;
  logic [STATUS_W-1:0] st;
  logic                push;
  logic                pop;
  logic                dwr;
  logic [SA_W-1:0]     push_addr;
  logic [MUL_W-1:0]    tq_prod;

  // read addresses: data at the operand, stack at the entry under the top
  assign data_raddr  = operand[DA_W-1:0];
  assign stack_raddr = SA_W'(cnt - CNT_W'(2));
  assign push_addr   = SA_W'(cnt - CNT_W'(1));

  // quotient of the jump target by the program depth, reciprocal multiply
  assign tq_prod = MUL_W'(jump_target) * MUL_W'(TQ_RECIP);

  // decode and error checks
  always_comb begin
    addr_ok     = !operand[WORD_W-1] && ($unsigned(operand) < WORD_W'(DATA_DEPTH));
    full        = (cnt == CNT_W'(STACK_DEPTH));
    empty       = (cnt == '0);
    short_stack = (cnt < CNT_W'(2));
    st   = ST_RUN;
    push = 1'b0;
    pop  = 1'b0;
    dwr  = 1'b0;
    if (halted) begin
      st = ST_IDLE;
    end else begin
      unique case (operation)
        OP_LD: begin
          if (!addr_ok) st = ST_ADDR;
          else if (full) st = ST_OVER;
          else push = 1'b1;
        end
        OP_ST: begin
          if (!addr_ok) st = ST_ADDR;
          else if (empty) st = ST_UNDER;
          else begin
            pop = 1'b1;
            dwr = 1'b1;
          end
        end
        OP_LDC: begin
          if (full) st = ST_OVER;
          else push = 1'b1;
        end
        OP_ADD, OP_SUB, OP_CMP: begin
          if (short_stack) st = ST_UNDER;
          else pop = 1'b1;
        end
        OP_BR: begin
          if (empty) st = ST_UNDER;
        end
        OP_RET: begin
          if (empty) st = ST_UNDER;
          else st = ST_RET;
        end
        default: begin
        end
      endcase
    end
    priority if (push) cnt_next = cnt + CNT_W'(1);
    else if (pop) cnt_next = cnt - CNT_W'(1);
    else cnt_next = cnt;
  end

  // control state and data memory clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      halted    <= 1'b0;
      iss_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      iss_valid <= accept;
      if (clearing) begin
        clr_addr <= clr_addr + DA_W'(1);
        if (clr_addr == DA_W'(DATA_DEPTH - 1)) clearing <= 1'b0;
      end
      if (accept) begin
        cnt <= cnt_next;
        if (st != ST_RUN) halted <= 1'b1;
      end
    end
  end

  // request register toward execute, with same-cycle write forwarding flags
  always_ff @(posedge clk) begin
    if (accept) begin
      iss.op        <= operation;
      iss.status    <= st;
      iss.stack_wr  <= push && !empty;
      iss.data_wr   <= dwr;
      iss.fwd_stack <= iss_valid && iss.stack_wr && (iss_saddr == stack_raddr);
      iss.fwd_data  <= iss_valid && iss.data_wr && (iss_daddr == data_raddr);
      iss.operand   <= operand;
      iss.target    <= jump_target;
      iss.tq        <= TGT_W'(tq_prod >> TQ_SHIFT);
      iss_saddr     <= push_addr;
      iss_daddr     <= data_raddr;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smx_exec.sv -----
// execute stage: cached top of stack, program counter, memory writes, result
// depends on smx_pkg
`timescale 1ns / 1ps
`default_nettype none

module smx_exec #(
  parameter int DATA_DEPTH    = 1024,
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           iss_valid,
  input  smx_pkg::issue_t                iss,
  input  logic [$clog2(DATA_DEPTH)-1:0]  iss_daddr,
  input  logic [$clog2(STACK_DEPTH)-1:0] iss_saddr,
  input  logic [smx_pkg::WORD_W-1:0]     stack_rdata,
  input  logic [smx_pkg::WORD_W-1:0]     data_rdata,
  output logic                           stack_we,
  output logic [$clog2(STACK_DEPTH)-1:0] stack_waddr,
  output logic [smx_pkg::WORD_W-1:0]     stack_wdata,
  output logic                           data_we,
  output logic [$clog2(DATA_DEPTH)-1:0]  data_waddr,
  output logic [smx_pkg::WORD_W-1:0]     data_wdata,
  output logic                           res_valid,
  output smx_pkg::result_t               res
);

  import smx_pkg::*;

  localparam int PC_W   = $clog2(PROGRAM_DEPTH);
  localparam int PROD_W = TGT_W + PC_W + 1;

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_inc;
  logic [PC_W-1:0]   pc_next;
  logic [PC_W-1:0]   tgt_wrap;
  logic [PROD_W-1:0] tgt_prod;
  logic [WORD_W-1:0] tos;
  logic [WORD_W-1:0] tos_next;
  logic [WORD_W-1:0] fwd_val;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] d;
  logic [WORD_W-1:0] cmp_val;
  logic              run;
  logic              taken;

  // memory writes: pushes spill the old top, st stores the top
  assign stack_we    = iss_valid && iss.stack_wr;
  assign stack_waddr = iss_saddr;
  assign stack_wdata = tos;
  assign data_we     = iss_valid && iss.data_wr;
  assign data_waddr  = iss_daddr;
  assign data_wdata  = tos;
  assign res_valid   = iss_valid;

  // operand selection, target wrap and alu
  always_comb begin
    y = iss.fwd_stack ? fwd_val : stack_rdata;
    d = iss.fwd_data ? fwd_val : data_rdata;
    tgt_prod = PROD_W'(iss.tq) * PROD_W'(PROGRAM_DEPTH);
    tgt_wrap = PC_W'(PROD_W'(iss.target) - tgt_prod);
    pc_inc   = (pc == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc + PC_W'(1);
    if ($signed(tos) > $signed(y)) cmp_val = WORD_W'(1);
    else if ($signed(tos) < $signed(y)) cmp_val = '1;
    else cmp_val = '0;
    run      = (iss.status == ST_RUN);
    tos_next = tos;
    taken    = 1'b0;
    unique case (iss.op)
      OP_LD:   tos_next = d;
      OP_ST:   tos_next = y;
      OP_LDC:  tos_next = iss.operand;
      OP_ADD:  tos_next = tos + y;
      OP_SUB:  tos_next = tos - y;
      OP_CMP:  tos_next = cmp_val;
      OP_JMP:  taken = 1'b1;
      OP_BR:   taken = (tos != '0);
      default: begin
      end
    endcase
    pc_next     = taken ? tgt_wrap : pc_inc;
    res.next_pc = run ? NEXT_W'(pc_next) : NEXT_W'(pc);
    res.status  = iss.status;
    res.value   = (iss.status == ST_RET) ? tos : '0;
  end

  // program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (iss_valid && run) begin
      pc <= pc_next;
    end
  end

  // top of stack and the value written this cycle, for forwarding
  always_ff @(posedge clk) begin
    fwd_val <= tos;
    if (iss_valid && run) tos <= tos_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/smx_checker.sv -----
// port-level checks of the stack machine executor, bound to the top level
// depends on smx_pkg and stack_machine_executor_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "stack_machine_executor_macros.svh"

module smx_checker #(
  parameter int PROGRAM_DEPTH = smx_pkg::PROGRAM_DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [smx_pkg::NEXT_W-1:0]        next_pc,
  input logic [smx_pkg::STATUS_W-1:0]      status,
  input logic signed [smx_pkg::WORD_W-1:0] result_value
);

  import smx_pkg::*;

  // a stalled result holds
  `SMX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_pc) && $stable(status) && $stable(result_value), "stalled result changed")

  // after reset the clear sweep blocks requests and nothing is pending
  `SMX_ASSERT_NEXT_RST(a_reset_quiet, rst, !in_ready && !out_valid, "busy right after reset")

  // only ret returns a value
  `SMX_ASSERT_NOW(a_value_ret, out_valid && (status != ST_RET), result_value == '0, "value without ret")

  // next_pc stays inside the program
  `SMX_ASSERT_NOW(a_pc_range, out_valid, 32'(next_pc) < PROGRAM_DEPTH, "next_pc out of program")

endmodule

bind stack_machine_executor smx_checker #(
  .PROGRAM_DEPTH(PROGRAM_DEPTH)
) u_smx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .next_pc     (next_pc),
  .status      (status),
  .result_value(result_value)
);

`default_nettype wire
